>>> design/fsc_pkg.sv
package fsc_pkg;

    // Field widths
    localparam int unsigned LOC_W     = 20;
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned DELAY_W   = 8;

    // Header cache keeps one dirty bit per erase block, eight blocks
    localparam int unsigned HDR_BLOCKS = 8;
    localparam int unsigned HDR_IDX_W  = 3;

    localparam logic [DELAY_W-1:0] FLUSH_DELAY_RST = 8'd100;
    localparam logic [DELAY_W-1:0] IDLE_MAX        = 8'd255;

    // Request action codes
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Result command kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_RD_HDR    = 3'd0,
        KIND_RD_FLASH  = 3'd1,
        KIND_WR_HDR    = 3'd2,
        KIND_WR_BLK    = 3'd3,
        KIND_FLUSH_HDR = 3'd4,
        KIND_FLUSH_BLK = 3'd5,
        KIND_LOAD_BLK  = 3'd6,
        KIND_RELEASE   = 3'd7
    } kind_t;

    // Classified request as it travels from front to back
    typedef enum logic [2:0] {
        OP_RD_HDR,
        OP_RD_FLASH,
        OP_WR_HDR,
        OP_WR_BLK,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [LOC_W-1:0] sector;
        logic [LOC_W-1:0] block;
        logic             changed;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH_HDR,
        ST_FLUSH_BLK,
        ST_LOAD,
        ST_WRITE,
        ST_RELEASE
    } state_t;

endpackage

>>> design/fsc_if.sv
interface fsc_req_if;
    import fsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [LOC_W-1:0]    sector;
    logic [COUNT_W-1:0]  sector_count;
    logic                header_changed;

    modport source (output valid, output action, output sector, output sector_count,
                    output header_changed, input ready);
    modport sink   (input valid, input action, input sector, input sector_count,
                    input header_changed, output ready);
endinterface

interface fsc_res_if;
    import fsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LOC_W-1:0]  location;
    logic              last;
    logic              busy_res;

    modport source (output valid, output kind, output location, output last,
                    output busy_res, input ready);
    modport sink   (input valid, input kind, input location, input last,
                    input busy_res, output ready);
endinterface

interface fsc_cfg_if;
    import fsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DELAY_W-1:0] flush_delay;

    modport source (output valid, output flush_delay, input ready);
    modport sink   (input valid, input flush_delay, output ready);
endinterface

>>> design/flash_sector_write_back_cache.sv
// Write-back sector cache controller. Each request is a read, a write or a timer tick;
// the block answers with the cache commands it causes, at most one result per cycle,
// the last one marked. A front stage classifies requests and computes the erase block,
// a two-entry queue decouples it from the back-end sequencer, and a result register
// holds each result until the sink takes it; a waiting result that is not taken holds
// the sequencer. A read, a header write, a write to the open block or a quiet tick is
// popped and then executed by the sequencer. A block switch then flushes each dirty
// header block and goes on through end of header scan, block flush, load and write,
// or only load and write when no block is open. A flushing tick flushes each dirty
// header block and goes on through end of header scan, block flush and release, and
// a tick that fires without flushing goes to release. There is no clearing pass after
// reset. flush_delay is written through the cfg channel, which is always ready; the
// user must write it only while no request is in flight. The block does not enforce this.
module flash_sector_write_back_cache #(
    parameter int unsigned HEADER_SECTORS    = 64,
    parameter int unsigned SECTORS_PER_BLOCK = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    fsc_req_if.sink   req,
    fsc_cfg_if.sink   cfg,
    fsc_res_if.source res
);
    import fsc_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    fsc_front #(
        .HEADER_SECTORS    (HEADER_SECTORS),
        .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    fsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    fsc_back #(
        .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .res       (res)
    );

`ifndef SYNTHESIS
    // A release ends its request with busy dropped and no location
    a_release_form: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_RELEASE |->
            res.last && !res.busy_res && res.location == '0)
        else $error("release result malformed");

    // Header flushes name one of eight blocks, run under busy, never end a request
    a_flush_hdr_form: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_FLUSH_HDR |->
            res.busy_res && !res.last && res.location < LOC_W'(HDR_BLOCKS))
        else $error("header flush result malformed");

    // A load or block flush never ends a request; a load is always followed by the block write
    a_load_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_LOAD_BLK || res.kind == KIND_FLUSH_BLK) |->
            !res.last)
        else $error("load or block flush marked last");

    // A stalled front request holds until the queue takes it
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fq_valid && !fq_ready |=> fq_valid && $stable(fq_cmd))
        else $error("front request dropped while queue full");
`endif

endmodule

>>> design/fsc_front.sv
module fsc_front #(
    parameter int unsigned HEADER_SECTORS    = 64,
    parameter int unsigned SECTORS_PER_BLOCK = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    fsc_req_if.sink       req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output fsc_pkg::cmd_t cmd
);
    import fsc_pkg::*;

    // Block number by reciprocal multiply: exact floor division for any 20-bit sector
    localparam int unsigned DIV_SH = LOC_W + $clog2(SECTORS_PER_BLOCK);
    localparam logic [LOC_W:0] DIV_M = (LOC_W + 1)'(
        ((64'd1 << DIV_SH) + 64'(SECTORS_PER_BLOCK) - 64'd1) / 64'(SECTORS_PER_BLOCK));
    localparam int unsigned PROD_W = 2 * LOC_W + 1;

    logic              valid_reg;
    logic              valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic              take;
    logic              keep;
    logic              is_hdr;
    logic [PROD_W-1:0] prod;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    // Compute erase block and header range
    assign prod   = PROD_W'(req.sector) * PROD_W'(DIV_M);
    assign is_hdr = req.sector < LOC_W'(HEADER_SECTORS);

    // Classify the request
    always_comb
    begin
        keep             = 1'b1;
        cmd_next.sector  = req.sector;
        cmd_next.block   = LOC_W'(prod >> DIV_SH);
        cmd_next.changed = req.header_changed;
        case (req.action)
            ACT_READ:  cmd_next.op = is_hdr ? OP_RD_HDR : OP_RD_FLASH;
            ACT_WRITE: cmd_next.op = is_hdr ? OP_WR_HDR : OP_WR_BLK;
            ACT_TICK:  cmd_next.op = OP_TICK;
            default:
            begin
                cmd_next.op = OP_TICK;
                keep        = 1'b0;
            end
        endcase
    end

    // Hold the classified request until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        if (take && keep)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && keep)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

>>> design/fsc_queue.sv
module fsc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  fsc_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output fsc_pkg::cmd_t pop_cmd
);
    import fsc_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/fsc_back.sv
module fsc_back #(
    parameter int unsigned SECTORS_PER_BLOCK = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    fsc_cfg_if.sink       cfg,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  fsc_pkg::cmd_t cmd,
    fsc_res_if.source     res
);
    import fsc_pkg::*;

    localparam int unsigned BLK_W = $clog2(((1 << LOC_W) - 1) / SECTORS_PER_BLOCK + 1);

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cur_reg;
    cmd_t                   cur_next;
    logic [DELAY_W-1:0]     flush_delay_reg;
    logic [HDR_BLOCKS-1:0]  mask_reg;
    logic [HDR_BLOCKS-1:0]  mask_next;
    logic                   blk_dirty_reg;
    logic                   blk_dirty_next;
    logic [BLK_W-1:0]       open_reg;
    logic [BLK_W-1:0]       open_next;
    logic [DELAY_W-1:0]     idle_reg;
    logic [DELAY_W-1:0]     idle_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic                   busy_reg;
    logic                   busy_next;

    logic                   res_valid_reg;
    logic                   res_valid_next;
    kind_t                  kind_reg;
    logic [LOC_W-1:0]       loc_reg;
    logic                   last_reg;
    logic                   busy_res_reg;

    logic                   emit;
    kind_t                  emit_kind;
    logic [LOC_W-1:0]       emit_loc;
    logic                   emit_last;

    logic                   out_free;
    logic                   blk_hit;
    logic                   open_nz;
    logic                   tick_fire;
    logic                   tick_flush;
    logic [HDR_IDX_W-1:0]   flush_idx;

    // Lowest dirty header block
    function automatic logic [HDR_IDX_W-1:0] low_bit(input logic [HDR_BLOCKS-1:0] m);
        logic [HDR_IDX_W-1:0] idx;
        idx = '0;
        for (int i = HDR_BLOCKS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = HDR_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign out_free   = !res_valid_reg || res.ready;
    assign cmd_ready  = state_reg == ST_IDLE;
    assign blk_hit    = BLK_W'(cur_reg.block) == open_reg;
    assign open_nz    = open_reg != '0;
    assign tick_fire  = armed_reg && ((mask_reg != '0) || blk_dirty_reg)
                        && (idle_reg >= flush_delay_reg);
    assign tick_flush = ((mask_reg != '0) && cur_reg.changed) || blk_dirty_reg;
    assign flush_idx  = low_bit(mask_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (cur_reg.op == OP_WR_BLK && !blk_hit)
                    begin
                        state_next = open_nz ? ST_FLUSH_HDR : ST_LOAD;
                    end
                    else if (cur_reg.op == OP_TICK && tick_fire)
                    begin
                        state_next = tick_flush ? ST_FLUSH_HDR : ST_RELEASE;
                    end
                end
            end
            ST_FLUSH_HDR:
            begin
                if (out_free && mask_reg == '0)
                begin
                    state_next = ST_FLUSH_BLK;
                end
            end
            ST_FLUSH_BLK:
            begin
                if (out_free)
                begin
                    state_next = (cur_reg.op == OP_TICK) ? ST_RELEASE : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE, ST_RELEASE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Cache state updates and result generation
    always_comb
    begin
        cur_next       = cur_reg;
        mask_next      = mask_reg;
        blk_dirty_next = blk_dirty_reg;
        open_next      = open_reg;
        idle_next      = idle_reg;
        armed_next     = armed_reg;
        busy_next      = busy_reg;
        emit           = 1'b0;
        emit_kind      = KIND_RELEASE;
        emit_loc       = '0;
        emit_last      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next = cmd;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    case (cur_reg.op)
                        OP_RD_HDR, OP_RD_FLASH:
                        begin
                            emit      = 1'b1;
                            emit_kind = (cur_reg.op == OP_RD_HDR) ? KIND_RD_HDR
                                                                  : KIND_RD_FLASH;
                            emit_loc  = cur_reg.sector;
                            emit_last = 1'b1;
                        end
                        OP_WR_HDR:
                        begin
                            mask_next  = mask_reg
                                | (HDR_BLOCKS'(1) << cur_reg.block[HDR_IDX_W-1:0]);
                            armed_next = 1'b1;
                            idle_next  = '0;
                            emit       = 1'b1;
                            emit_kind  = KIND_WR_HDR;
                            emit_loc   = cur_reg.sector;
                            emit_last  = 1'b1;
                        end
                        OP_WR_BLK:
                        begin
                            if (blk_hit)
                            begin
                                blk_dirty_next = 1'b1;
                                armed_next     = 1'b1;
                                idle_next      = '0;
                                emit           = 1'b1;
                                emit_kind      = KIND_WR_BLK;
                                emit_loc       = cur_reg.sector;
                                emit_last      = 1'b1;
                            end
                            else if (open_nz)
                            begin
                                busy_next = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (tick_fire)
                            begin
                                armed_next = 1'b0;
                                idle_next  = '0;
                                if (tick_flush)
                                begin
                                    busy_next = 1'b1;
                                end
                            end
                            else if (armed_reg && idle_reg != IDLE_MAX)
                            begin
                                idle_next = idle_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FLUSH_HDR:
            begin
                if (out_free && mask_reg != '0)
                begin
                    mask_next = mask_reg & ~(HDR_BLOCKS'(1) << flush_idx);
                    emit      = 1'b1;
                    emit_kind = KIND_FLUSH_HDR;
                    emit_loc  = LOC_W'(flush_idx);
                end
            end
            ST_FLUSH_BLK:
            begin
                if (out_free && blk_dirty_reg && open_nz)
                begin
                    blk_dirty_next = 1'b0;
                    emit           = 1'b1;
                    emit_kind      = KIND_FLUSH_BLK;
                    emit_loc       = LOC_W'(open_reg);
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    open_next = BLK_W'(cur_reg.block);
                    emit      = 1'b1;
                    emit_kind = KIND_LOAD_BLK;
                    emit_loc  = cur_reg.block;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    blk_dirty_next = 1'b1;
                    armed_next     = 1'b1;
                    idle_next      = '0;
                    emit           = 1'b1;
                    emit_kind      = KIND_WR_BLK;
                    emit_loc       = cur_reg.sector;
                    emit_last      = 1'b1;
                end
            end
            ST_RELEASE:
            begin
                if (out_free)
                begin
                    busy_next = 1'b0;
                    emit      = 1'b1;
                    emit_kind = KIND_RELEASE;
                    emit_loc  = '0;
                    emit_last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            flush_delay_reg <= FLUSH_DELAY_RST;
            mask_reg        <= '0;
            blk_dirty_reg   <= 1'b0;
            open_reg        <= '0;
            idle_reg        <= '0;
            armed_reg       <= 1'b0;
            busy_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            blk_dirty_reg <= blk_dirty_next;
            open_reg      <= open_next;
            idle_reg      <= idle_next;
            armed_reg     <= armed_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                flush_delay_reg <= cfg.flush_delay;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            kind_reg     <= emit_kind;
            loc_reg      <= emit_loc;
            last_reg     <= emit_last;
            busy_res_reg <= busy_next;
        end
    end

    assign cfg.ready    = 1'b1;
    assign res.valid    = res_valid_reg;
    assign res.kind     = kind_reg;
    assign res.location = loc_reg;
    assign res.last     = last_reg;
    assign res.busy_res = busy_res_reg;

endmodule
